FILE: design/type_length_frame_parser_macros.svh
// Assertion helpers used by the frame parser RTL.
`ifndef TYPE_LENGTH_FRAME_PARSER_MACROS_SVH
`define TYPE_LENGTH_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TLFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlfp assertion failed");

// Next-cycle implication, checked out of reset.
`define TLFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlfp assertion failed");

`endif

FILE: design/tlfp_pkg.sv
`timescale 1ns / 1ps

package tlfp_pkg;

  // Header is one type byte plus a four-byte big-endian length
  localparam int unsigned HdrBytes = 5;
  localparam int unsigned LenW     = 32;
  localparam int unsigned LimitW   = 33;
  localparam int unsigned CountW   = 3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_TOO_LARGE = 2'd2,
    KIND_REJECTED  = 2'd3
  } kind_e;

  // Input register contents handed to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_slot_t;

  typedef struct packed {
    kind_e            result_kind;
    logic [7:0]       msg_type;
    logic [LenW-1:0]  payload_length;
    logic [7:0]       payload_byte;
    logic [LenW-1:0]  byte_offset;
    logic             last_of_frame;
  } result_t;

endpackage

FILE: design/tlfp_channels.sv
`timescale 1ns / 1ps

// Raw stream byte channel
interface tlfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// Parser result word channel
interface tlfp_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic [7:0]                   msg_type;
  logic [tlfp_pkg::LenW-1:0]    payload_length;
  logic [7:0]                   payload_byte;
  logic [tlfp_pkg::LenW-1:0]    byte_offset;
  logic                         last_of_frame;

  modport source (
    output valid, output result_kind, output msg_type, output payload_length,
    output payload_byte, output byte_offset, output last_of_frame, input ready
  );
  modport sink (
    input valid, input result_kind, input msg_type, input payload_length,
    input payload_byte, input byte_offset, input last_of_frame, output ready
  );
endinterface

// Frame size limit write channel
interface tlfp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tlfp_pkg::LimitW-1:0] max_frame_bytes;

  modport source (output valid, output max_frame_bytes, input ready);
  modport sink (input valid, input max_frame_bytes, output ready);
endinterface

FILE: design/tlfp_in_stage.sv
`timescale 1ns / 1ps

module tlfp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tlfp_byte_if.sink            byte_i,
  input  logic                 advance_i,
  output tlfp_pkg::byte_slot_t slot_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  // Accept when the slot is empty or drains this cycle
  assign byte_i.ready = !valid_q || advance_i;
  assign take         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the stream byte until the parser takes it
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= byte_i.data_byte;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;

endmodule

FILE: design/tlfp_parse.sv
`timescale 1ns / 1ps
`include "type_length_frame_parser_macros.svh"

module tlfp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlfp_pkg::byte_slot_t slot_i,
  output logic                 advance_o,
  tlfp_cfg_if.sink             cfg_i,
  tlfp_result_if.source        result_o
);

  tlfp_pkg::phase_e                 phase_q, phase_d;
  logic [tlfp_pkg::CountW-1:0]      header_count_q, header_count_d;
  logic [7:0]                       frame_type_q, frame_type_d;
  logic [tlfp_pkg::LenW-1:0]        frame_length_q, frame_length_d;
  logic [tlfp_pkg::LenW-1:0]        payload_seen_q, payload_seen_d;
  logic [tlfp_pkg::LimitW-1:0]      limit_q;
  logic                             res_valid_q, res_valid_d;
  tlfp_pkg::result_t                res_q, res_new;
  logic                             emit;
  logic                             is_last;
  logic [tlfp_pkg::LenW-1:0]        len_shift;
  logic [tlfp_pkg::LimitW-1:0]      total;

  // Limit register; the user must write it only while the parser is idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.max_frame_bytes;
    end
  end

  // Move the input byte on when the result register is free or drains
  assign advance_o = slot_i.valid && (!res_valid_q || result_o.ready);

  assign len_shift = {frame_length_q[tlfp_pkg::LenW-9:0], slot_i.data};
  assign total     = {1'b0, len_shift} + tlfp_pkg::LimitW'(tlfp_pkg::HdrBytes);
  assign is_last   = (payload_seen_q == frame_length_q - tlfp_pkg::LenW'(1));

  // Parse one byte against the current frame state
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    frame_type_d   = frame_type_q;
    frame_length_d = frame_length_q;
    payload_seen_d = payload_seen_q;
    emit           = 1'b0;
    res_new        = '0;
    res_new.result_kind = tlfp_pkg::KIND_PAYLOAD;
    case (phase_q)
      tlfp_pkg::PH_ERROR: begin
        emit                = 1'b1;
        res_new.result_kind = tlfp_pkg::KIND_REJECTED;
      end
      tlfp_pkg::PH_PAYLOAD: begin
        emit                   = 1'b1;
        res_new.result_kind    = tlfp_pkg::KIND_PAYLOAD;
        res_new.msg_type       = frame_type_q;
        res_new.payload_length = frame_length_q;
        res_new.payload_byte   = slot_i.data;
        res_new.byte_offset    = payload_seen_q;
        res_new.last_of_frame  = is_last;
        payload_seen_d         = payload_seen_q + tlfp_pkg::LenW'(1);
        if (is_last) begin
          phase_d        = tlfp_pkg::PH_HEADER;
          header_count_d = '0;
          payload_seen_d = '0;
        end
      end
      default: begin
        // Header collection; an unused phase code behaves the same
        if (header_count_q == '0) begin
          frame_type_d   = slot_i.data;
          frame_length_d = '0;
          header_count_d = tlfp_pkg::CountW'(1);
        end else begin
          frame_length_d = len_shift;
          if (header_count_q == tlfp_pkg::CountW'(tlfp_pkg::HdrBytes - 1)) begin
            header_count_d         = '0;
            payload_seen_d         = '0;
            res_new.msg_type       = frame_type_q;
            res_new.payload_length = len_shift;
            if ((limit_q != '0) && (total > limit_q)) begin
              phase_d             = tlfp_pkg::PH_ERROR;
              emit                = 1'b1;
              res_new.result_kind = tlfp_pkg::KIND_TOO_LARGE;
            end else if (len_shift == '0) begin
              phase_d               = tlfp_pkg::PH_HEADER;
              emit                  = 1'b1;
              res_new.result_kind   = tlfp_pkg::KIND_EMPTY;
              res_new.last_of_frame = 1'b1;
            end else begin
              phase_d = tlfp_pkg::PH_PAYLOAD;
            end
          end else begin
            header_count_d = header_count_q + tlfp_pkg::CountW'(1);
          end
        end
      end
    endcase
  end

  // Frame state advances only on a byte that moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= tlfp_pkg::PH_HEADER;
      header_count_q <= '0;
      frame_type_q   <= '0;
      frame_length_q <= '0;
      payload_seen_q <= '0;
    end else if (advance_o) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      frame_type_q   <= frame_type_d;
      frame_length_q <= frame_length_d;
      payload_seen_q <= payload_seen_d;
    end
  end

  // Result register: drop on take, load on a new word
  always_comb begin
    res_valid_d = res_valid_q;
    if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (advance_o && emit) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      res_q <= res_new;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.result_kind    = res_q.result_kind;
  assign result_o.msg_type       = res_q.msg_type;
  assign result_o.payload_length = res_q.payload_length;
  assign result_o.payload_byte   = res_q.payload_byte;
  assign result_o.byte_offset    = res_q.byte_offset;
  assign result_o.last_of_frame  = res_q.last_of_frame;

  // Error phase is left only through reset
  `TLFP_ASSERT_NEXT(a_error_sticky, phase_q == tlfp_pkg::PH_ERROR, phase_q == tlfp_pkg::PH_ERROR)
  // Header counter stays below the five header bytes
  `TLFP_ASSERT_NOW(a_count_range, 1'b1, header_count_q < tlfp_pkg::CountW'(tlfp_pkg::HdrBytes))
  // Payload offset never reaches the frame length
  `TLFP_ASSERT_NOW(a_offset_bound, phase_q == tlfp_pkg::PH_PAYLOAD, payload_seen_q < frame_length_q)
  // Last mark only on payload or empty-frame words
  `TLFP_ASSERT_NOW(a_last_kind, res_valid_q && res_q.last_of_frame, (res_q.result_kind == tlfp_pkg::KIND_PAYLOAD) || (res_q.result_kind == tlfp_pkg::KIND_EMPTY))

endmodule

FILE: design/type_length_frame_parser.sv
`timescale 1ns / 1ps

// Type-length frame parser: takes one stream byte per clock while results are
// taken and gives at most one result word per byte via the input register,
// then result register. The header (type byte, 32-bit big-endian length) gives
// no words until it completes, then an empty-frame word, a too-large word, or
// nothing; each payload byte gives one word with its offset and last mark.
// After a too-large frame every byte is rejected until reset. A byte is taken
// every cycle while results are taken; byte ready follows the result ready
// through the input register within the same cycle. The size limit is written
// on the configuration channel, always ready, and is read only when a header
// completes.
module type_length_frame_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlfp_byte_if.sink     byte_i,
  tlfp_cfg_if.sink      cfg_i,
  tlfp_result_if.source result_o
);

  tlfp_pkg::byte_slot_t slot;
  logic                 advance;

  tlfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .slot_o    (slot)
  );

  tlfp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .slot_i    (slot),
    .advance_o (advance),
    .cfg_i     (cfg_i),
    .result_o  (result_o)
  );

endmodule
